/* rtl/tst_pkg.sv */
`default_nettype none
package tst_pkg;

    // table geometry
    localparam int ENTRIES = 512;
    localparam int TAG_W   = 80;
    localparam int IDX_W   = $clog2(ENTRIES);
    // wide enough to hold ENTRIES itself
    localparam int SCAN_W  = $clog2(ENTRIES + 1);
    localparam int LIM_W   = (SCAN_W > 10) ? SCAN_W : 10;
    localparam int SLX_W   = (SCAN_W > 9) ? SCAN_W : 9;
    localparam int RIX_W   = (IDX_W > 9) ? IDX_W : 9;

    localparam logic [TAG_W-1:0] ERASED_TAG = '1;

    typedef enum logic [2:0] {
        CMD_SEARCH = 3'd0,
        CMD_FIND   = 3'd1,
        CMD_COUNT  = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

/* rtl/tag_slot_table.sv */
`default_nettype none
// Tag slot table: ENTRIES slots of 80-bit tags held in a single-port-write,
// registered-read memory; an all-ones slot counts as empty. One command word
// is taken at a time. After reset a clearing pass writes every slot to all
// ones, during which s_ready stays low. Search and find-empty walk the
// table from slot 0 through one shared 80-bit comparator, one slot per
// cycle, and stop at the first hit. Count-empty walks min(zone_limit,
// ENTRIES) slots. Write and delete write the addressed slot and then
// answer. The walk rate is set by the single memory read port. The result
// sits in an output register; the next word is accepted once the
// sequencer is idle.
module tag_slot_table
    import tst_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_command,
    input  wire logic [63:0] s_tag_low,
    input  wire logic [15:0] s_tag_high,
    input  wire logic [8:0]  s_slot_index,
    input  wire logic [9:0]  s_zone_limit,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [8:0]       m_result_index,
    output logic [9:0]       m_empty_count
);

    // tag memory, low bytes in [63:0], high bytes in [79:64]
    logic [TAG_W-1:0] mem [ENTRIES];
    logic [TAG_W-1:0] mem_q_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [TAG_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    state_t state_reg, state_next;

    cmd_t              cmd_reg, cmd_next;
    logic [TAG_W-1:0]  key_reg, key_next;       // search key or write data
    logic [SCAN_W-1:0] scan_addr_reg, scan_addr_next;
    logic [SCAN_W-1:0] scan_end_reg, scan_end_next;
    logic [8:0]        slot_reg, slot_next;
    logic              pend_reg, pend_next;     // mem_q_reg holds a slot to check
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;

    logic              found_reg, found_next;
    logic [8:0]        res_idx_reg, res_idx_next;
    logic [LIM_W-1:0]  count_reg, count_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [8:0]        m_idx_reg, m_idx_next;
    logic [9:0]        m_cnt_reg, m_cnt_next;

    logic              s_fire;
    logic              hit;
    logic [LIM_W-1:0]  zone_ext;
    logic [SLX_W-1:0]  slot_ext;
    logic [RIX_W-1:0]  pend_idx_ext;
    logic              slot_ok;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_result_index = m_idx_reg;
    assign m_empty_count  = m_cnt_reg;

    // the shared comparator: search key, or all ones for empty checks
    assign hit = pend_reg && (mem_q_reg == key_reg);

    assign zone_ext     = LIM_W'(s_zone_limit);
    assign slot_ext     = SLX_W'(slot_reg);
    assign slot_ok      = slot_ext < SLX_W'(ENTRIES);
    assign pend_idx_ext = RIX_W'(pend_idx_reg);
    assign mem_raddr    = scan_addr_reg[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_addr_reg <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            scan_addr_reg <= scan_addr_next;
            pend_reg      <= pend_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        scan_end_reg <= scan_end_next;
        slot_reg     <= slot_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        res_idx_reg  <= res_idx_next;
        count_reg    <= count_next;
        m_found_reg  <= m_found_next;
        m_idx_reg    <= m_idx_next;
        m_cnt_reg    <= m_cnt_next;
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        scan_addr_next = scan_addr_reg;
        scan_end_next  = scan_end_reg;
        slot_next      = slot_reg;
        pend_next      = 1'b0;
        pend_idx_next  = pend_idx_reg;
        found_next     = found_reg;
        res_idx_next   = res_idx_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_idx_next     = m_idx_reg;
        m_cnt_next     = m_cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = scan_addr_reg[IDX_W-1:0];
        mem_wdata      = ERASED_TAG;

        case (state_reg)
            ST_CLEAR: begin
                mem_we         = 1'b1;
                scan_addr_next = scan_addr_reg + 1'b1;
                if (scan_addr_reg == SCAN_W'(ENTRIES - 1)) begin
                    scan_addr_next = '0;
                    state_next     = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next       = cmd_t'(s_command);
                    slot_next      = s_slot_index;
                    scan_addr_next = '0;
                    found_next     = 1'b0;
                    res_idx_next   = '0;
                    count_next     = '0;
                    scan_end_next  = SCAN_W'(ENTRIES);
                    key_next       = ERASED_TAG;
                    case (s_command) inside
                        CMD_SEARCH, CMD_WRITE: key_next = {s_tag_high, s_tag_low};
                        default: key_next = ERASED_TAG;
                    endcase
                    case (s_command) inside
                        CMD_SEARCH, CMD_FIND: begin
                            state_next = ST_SCAN;
                        end
                        CMD_COUNT: begin
                            state_next = ST_SCAN;
                            if (zone_ext < LIM_W'(ENTRIES)) begin
                                scan_end_next = SCAN_W'(zone_ext);
                            end
                        end
                        CMD_WRITE, CMD_DELETE: begin
                            state_next = ST_WRITE;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (hit && cmd_reg != CMD_COUNT) begin
                    found_next   = 1'b1;
                    res_idx_next = pend_idx_ext[8:0];
                    state_next   = ST_FINISH;
                end else begin
                    if (hit) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (scan_addr_reg < scan_end_reg) begin
                        // read issued now, checked next cycle
                        pend_next      = 1'b1;
                        pend_idx_next  = scan_addr_reg[IDX_W-1:0];
                        scan_addr_next = scan_addr_reg + 1'b1;
                    end else if (!pend_reg) begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_WRITE: begin
                res_idx_next = slot_reg;
                mem_waddr    = slot_ext[IDX_W-1:0];
                mem_wdata    = key_reg;
                if (slot_ok) begin
                    mem_we     = 1'b1;
                    found_next = 1'b1;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    m_idx_next   = res_idx_reg;
                    m_cnt_next   = count_reg[9:0];
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire
